/* design/mbx_pkg.sv */
// ----------------------------------------------------------------------------
// Mailbox controller package
// Access kinds, command codes and the request type shared by the modules.
// ----------------------------------------------------------------------------
package mbx_pkg;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [7:0] CMD_BUTTONS = 8'h01;
  localparam logic [7:0] CMD_VERSION = 8'h08;
  localparam logic [7:0] CMD_LEDS    = 8'h20;
  localparam logic [7:0] CMD_COINS   = 8'h40;
  localparam logic [7:0] CMD_PARAM_A = 8'h80;
  localparam logic [7:0] CMD_PARAM_B = 8'h81;
  localparam logic [7:0] CMD_RESET   = 8'hFF;

  localparam logic [7:0] VERSION_BYTE = 8'h54;
  localparam logic [7:0] STATUS_FULL  = 8'h01;
  localparam logic [7:0] STATUS_AWAIT = 8'h80;

  typedef struct packed {
    logic        step;
    logic [1:0]  kind;
    logic [7:0]  write_data;
    logic [15:0] buttons;
  } mbx_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] led_bits;
    logic [3:0] coin_counter_pulses;
  } mbx_rsp_t;

  // Index of the lowest set line plus one, zero when no line is set.
  function automatic logic [7:0] encode_lowest(input logic [15:0] lines);
    logic [7:0] code;
    code = 8'd0;
    for (int i = 15; i >= 0; i--) begin
      if (lines[i]) begin
        code = 8'(i + 1);
      end
    end
    return code;
  endfunction

endpackage

/* design/io_mailbox_command_controller.sv */
// ----------------------------------------------------------------------------
// I/O mailbox command controller
// The accepting edge loads the input register, and the staged item loads the
// result register when it advances.
// Throughput: one item per cycle; once both registers hold items, a stall on
// the result side holds the input side in the same cycle.
// Reset: synchronous; clears both valid flags and returns all controller
// state to its reset values (command register 0xFF, all else zero).
// ----------------------------------------------------------------------------
module io_mailbox_command_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  write_data,
  input  logic [15:0] buttons,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [7:0]  led_bits,
  output logic [3:0]  coin_counter_pulses
);

  logic              stage_valid;
  logic [1:0]        stage_kind;
  logic [7:0]        stage_write_data;
  logic [15:0]       stage_buttons;
  logic              advance;
  mbx_pkg::mbx_req_t req;
  mbx_pkg::mbx_rsp_t rsp;

  // The staged item moves on when the result register is empty or drains.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_kind       <= kind;
      stage_write_data <= write_data;
      stage_buttons    <= buttons;
    end
  end

  assign req.step       = stage_valid && advance;
  assign req.kind       = stage_kind;
  assign req.write_data = stage_write_data;
  assign req.buttons    = stage_buttons;

  mbx_core u_core (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.step) begin
      read_data           <= rsp.read_data;
      led_bits            <= rsp.led_bits;
      coin_counter_pulses <= rsp.coin_counter_pulses;
    end
  end

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> (stage_valid && $stable(stage_kind) &&
      $stable(stage_write_data) && $stable(stage_buttons)))
    else $error("staged item lost during stall");

  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    req.step |=> out_valid)
    else $error("processed item produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!stage_valid || !out_valid) |-> in_ready)
    else $error("input stalled with free space");

endmodule

/* design/mbx_core.sv */
// ----------------------------------------------------------------------------
// Mailbox controller core
// Holds the controller state, decodes one access per step and forms the
// response from the state as it stands after the access.
// ----------------------------------------------------------------------------
module mbx_core (
  input  logic              clk,
  input  logic              rst,
  input  mbx_pkg::mbx_req_t req,
  output mbx_pkg::mbx_rsp_t rsp
);

  logic [7:0] command_register, command_register_next;
  logic [7:0] return_byte, return_byte_next;
  logic       output_full, output_full_next;
  logic       awaiting_data, awaiting_data_next;
  logic [7:0] led_latch, led_latch_next;
  logic [7:0] coin_latch, coin_latch_next;
  logic [7:0] read_data;

  always_comb begin
    command_register_next = command_register;
    return_byte_next      = return_byte;
    output_full_next      = output_full;
    awaiting_data_next    = awaiting_data;
    led_latch_next        = led_latch;
    coin_latch_next       = coin_latch;
    read_data             = 8'd0;
    unique case (req.kind)
      mbx_pkg::KIND_READ: begin
        read_data        = return_byte;
        output_full_next = 1'b0;
      end
      mbx_pkg::KIND_WRITE: begin
        if (awaiting_data) begin
          // Data byte for the stored command.
          awaiting_data_next = 1'b0;
          if (command_register == mbx_pkg::CMD_LEDS) begin
            led_latch_next = req.write_data;
          end else if (command_register == mbx_pkg::CMD_COINS) begin
            coin_latch_next = req.write_data;
          end
        end else begin
          command_register_next = req.write_data;
          unique case (req.write_data) inside
            mbx_pkg::CMD_BUTTONS: begin
              return_byte_next = mbx_pkg::encode_lowest(req.buttons);
              output_full_next = 1'b1;
            end
            mbx_pkg::CMD_VERSION: begin
              return_byte_next = mbx_pkg::VERSION_BYTE;
              output_full_next = 1'b1;
            end
            mbx_pkg::CMD_LEDS, mbx_pkg::CMD_COINS,
            mbx_pkg::CMD_PARAM_A, mbx_pkg::CMD_PARAM_B: begin
              awaiting_data_next = 1'b1;
            end
            mbx_pkg::CMD_RESET: begin
              command_register_next = mbx_pkg::CMD_RESET;
              return_byte_next      = 8'd0;
              output_full_next      = 1'b0;
              awaiting_data_next    = 1'b0;
              led_latch_next        = 8'd0;
              coin_latch_next       = 8'd0;
            end
            default: begin
            end
          endcase
        end
      end
      mbx_pkg::KIND_STATUS: begin
        read_data = (output_full ? mbx_pkg::STATUS_FULL : 8'd0) |
                    (awaiting_data ? mbx_pkg::STATUS_AWAIT : 8'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_register <= mbx_pkg::CMD_RESET;
      return_byte      <= 8'd0;
      output_full      <= 1'b0;
      awaiting_data    <= 1'b0;
      led_latch        <= 8'd0;
      coin_latch       <= 8'd0;
    end else if (req.step) begin
      command_register <= command_register_next;
      return_byte      <= return_byte_next;
      output_full      <= output_full_next;
      awaiting_data    <= awaiting_data_next;
      led_latch        <= led_latch_next;
      coin_latch       <= coin_latch_next;
    end
  end

  // Counter outputs are active low in the latch, bits 1 to 4.
  assign rsp.read_data           = read_data;
  assign rsp.led_bits            = led_latch_next;
  assign rsp.coin_counter_pulses = ~coin_latch_next[4:1];

  a_status_no_change: assert property (@(posedge clk) disable iff (rst)
    (req.step && req.kind == mbx_pkg::KIND_STATUS) |=>
      ($stable(output_full) && $stable(awaiting_data) && $stable(led_latch) &&
       $stable(coin_latch) && $stable(return_byte)))
    else $error("status read changed controller state");

  a_read_clears_full: assert property (@(posedge clk) disable iff (rst)
    (req.step && req.kind == mbx_pkg::KIND_READ) |=> !output_full)
    else $error("data read left output full set");

  a_reset_command: assert property (@(posedge clk) disable iff (rst)
    (req.step && req.kind == mbx_pkg::KIND_WRITE && !awaiting_data &&
     req.write_data == mbx_pkg::CMD_RESET) |=>
      (command_register == mbx_pkg::CMD_RESET && !awaiting_data && !output_full &&
       led_latch == 8'd0 && coin_latch == 8'd0 && return_byte == 8'd0))
    else $error("reset command did not restore reset state");

endmodule
